[rtl/core/wfr_pkg.sv]
// Shared constants, types and codes of the windowed failure ratio statistics core.
package wfr_pkg;

  // Sizing
  localparam int WINDOW_STEPS = 100;
  localparam int COUNT_BITS   = 16;
  localparam int SLOT_BITS    = (WINDOW_STEPS > 1) ? $clog2(WINDOW_STEPS) : 1;
  localparam int FILL_BITS    = $clog2(WINDOW_STEPS + 1);
  localparam int SUM_BITS     = COUNT_BITS + FILL_BITS;
  localparam int REM_BITS     = SUM_BITS + 1;

  // Fixed field widths of the stream payloads
  localparam int CFG_BITS     = 16;
  localparam int FRAC_BITS    = 16;
  localparam int RATIO_BITS   = 17;
  localparam int WSUM_BITS    = 23;
  localparam int DIV_CNT_BITS = $clog2(RATIO_BITS);
  localparam int CMP_BITS     = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  localparam int S_TDATA_BITS = 8;
  localparam int S_TUSER_BITS = 1;
  localparam int M_TDATA_RAW  = 3 * RATIO_BITS + WSUM_BITS;
  localparam int M_TDATA_BITS = ((M_TDATA_RAW + 7) / 8) * 8;
  localparam int M_TUSER_BITS = 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [RATIO_BITS-1:0] ratio_t;

  // One window entry as stored in the RAM
  typedef struct packed {
    count_t vel;
    count_t yaw;
    count_t fail;
    count_t att;
  } slot_t;

  localparam int SLOT_DATA_BITS = $bits(slot_t);

  localparam count_t COUNT_MAX = '1;
  localparam ratio_t RATIO_ONE = ratio_t'(1) << FRAC_BITS;

  // Request kinds carried in s_axis_tuser
  localparam logic REQ_ATTEMPT  = 1'b0;
  localparam logic REQ_STEP_END = 1'b1;

  // Which ratio the shared divider is working on
  typedef enum logic [1:0] {
    R_FAIL,
    R_YAW,
    R_VEL
  } ratio_sel_e;

endpackage

[rtl/core/wfr_ram.sv]
// Generic single-port-write, registered-read RAM.
module wfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/windowed_failure_ratio_stats_core.sv]
// Top level of the windowed failure ratio statistics core.
// Attempt event: the result is registered in the output register, through S_EMIT while that register is held;
//   one attempt per cycle while the result side keeps taking results.
// Step end entering the window: update, setup, three 17-step divisions on the shared restoring
//   divider (skipped when the window holds no attempts), emit; rejected step: as an attempt event.
// Reset (rst_ni low, async): clears counters, sums, ratios, fill and min_attempts = 1;
//   the window RAM is not cleared, the fill count keeps unwritten entries unread.
module windowed_failure_ratio_stats_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  // Configuration: min_attempts
  input  logic                             cfg_we_i,
  input  logic [wfr_pkg::CFG_BITS-1:0]     cfg_wdata_i,

  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] success, [1] failed_yaw, [2] failed_vel, [7:3] zero
  input  logic [wfr_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  // [0] req_type
  input  logic [wfr_pkg::S_TUSER_BITS-1:0] s_axis_tuser,

  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [16:0] ratio_failed, [33:17] ratio_failed_yaw, [50:34] ratio_failed_vel,
  // [73:51] window_attempts, [79:74] zero
  output logic [wfr_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  // [0] ratios_valid
  output logic [wfr_pkg::M_TUSER_BITS-1:0] m_axis_tuser
);

  import wfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,   // take items; attempts are counted here
    S_UPD,    // evict oldest entry (if full), store the step, update sums
    S_PREP,   // zero-attempt check, load first numerator
    S_DIV,    // one quotient bit per cycle, three ratios in turn
    S_EMIT    // wait for the output register, then load the snapshot
  } state_e;

  state_e                  state_q, state_d;

  logic [CFG_BITS-1:0]     min_att_q, min_att_d;

  count_t                  st_att_q, st_att_d;
  count_t                  st_fail_q, st_fail_d;
  count_t                  st_yaw_q, st_yaw_d;
  count_t                  st_vel_q, st_vel_d;

  logic [FILL_BITS-1:0]    fill_q, fill_d;
  logic [SLOT_BITS-1:0]    oldest_q, oldest_d;

  sum_t                    sum_att_q, sum_att_d;
  sum_t                    sum_fail_q, sum_fail_d;
  sum_t                    sum_yaw_q, sum_yaw_d;
  sum_t                    sum_vel_q, sum_vel_d;

  ratio_t                  ratio_q [3];
  ratio_t                  ratio_d [3];
  logic                    ratio_ok_q, ratio_ok_d;

  // Shared divider registers
  ratio_sel_e              sel_q, sel_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [REM_BITS-1:0]     rem_q, rem_d;
  ratio_t                  quo_q, quo_d;

  // Output register
  logic                    out_vld_q, out_vld_d;
  logic [M_TDATA_BITS-1:0] out_data_q, out_data_d;
  logic                    out_user_q, out_user_d;

  // Window RAM
  logic                    ram_we;
  logic [SLOT_BITS-1:0]    ram_waddr;
  slot_t                   ram_wdata;
  logic [SLOT_DATA_BITS-1:0] ram_rdata;
  slot_t                   old_slot;

  logic                    in_xact;
  logic                    out_free;
  logic                    win_full;
  logic                    step_enters;
  logic [SLOT_BITS:0]      slot_sum;
  logic [SLOT_BITS-1:0]    free_slot;
  logic [REM_BITS:0]       trial;
  logic                    qbit;
  logic [REM_BITS-1:0]     rem_sub;
  ratio_t                  quo_next;
  sum_t                    next_num;
  logic [M_TDATA_BITS-1:0] snap_data;

  // Oldest entry is always being read; it is valid in the cycle after oldest_q settles
  wfr_ram #(
    .WIDTH (SLOT_DATA_BITS),
    .DEPTH (WINDOW_STEPS)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  assign old_slot = slot_t'(ram_rdata);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign win_full    = (fill_q == FILL_BITS'(WINDOW_STEPS));
  assign step_enters = (CMP_BITS'(st_att_q) >= CMP_BITS'(min_att_q));

  // Next free slot while filling: (oldest + fill) mod depth, sum stays below 2 * depth
  assign slot_sum  = (SLOT_BITS + 1)'(oldest_q) + (SLOT_BITS + 1)'(fill_q);
  assign free_slot = (slot_sum >= (SLOT_BITS + 1)'(WINDOW_STEPS))
                   ? SLOT_BITS'(slot_sum - (SLOT_BITS + 1)'(WINDOW_STEPS))
                   : SLOT_BITS'(slot_sum);

  // Restoring divider step. The numerator never exceeds the attempt sum, so the
  // first compare yields the integer bit and the rest are fraction bits.
  assign trial    = {1'b0, rem_q} - (REM_BITS + 1)'(sum_att_q);
  assign qbit     = !trial[REM_BITS];
  assign rem_sub  = qbit ? trial[REM_BITS-1:0] : rem_q;
  assign quo_next = {quo_q[RATIO_BITS-2:0], qbit};

  always_comb begin
    case (sel_q)
      R_FAIL:  next_num = sum_yaw_q;
      R_YAW:   next_num = sum_vel_q;
      default: next_num = sum_fail_q;
    endcase
  end

  // Snapshot of the visible state
  assign snap_data = M_TDATA_BITS'({sum_att_q[WSUM_BITS-1:0] & {WSUM_BITS{1'b1}},
                                    ratio_q[2], ratio_q[1], ratio_q[0]});

  always_comb begin
    state_d    = state_q;
    min_att_d  = min_att_q;
    st_att_d   = st_att_q;
    st_fail_d  = st_fail_q;
    st_yaw_d   = st_yaw_q;
    st_vel_d   = st_vel_q;
    fill_d     = fill_q;
    oldest_d   = oldest_q;
    sum_att_d  = sum_att_q;
    sum_fail_d = sum_fail_q;
    sum_yaw_d  = sum_yaw_q;
    sum_vel_d  = sum_vel_q;
    ratio_d    = ratio_q;
    ratio_ok_d = ratio_ok_q;
    sel_d      = sel_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    ram_we     = 1'b0;
    ram_waddr  = oldest_q;
    ram_wdata  = '{vel: st_vel_q, yaw: st_yaw_q, fail: st_fail_q, att: st_att_q};

    if (cfg_we_i) begin
      min_att_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xact) begin
          if (s_axis_tuser[0] == REQ_STEP_END && step_enters) begin
            state_d = S_UPD;
          end else begin
            if (s_axis_tuser[0] == REQ_ATTEMPT) begin
              st_att_d = (st_att_q == COUNT_MAX) ? st_att_q : st_att_q + 1'b1;
              if (!s_axis_tdata[0]) begin
                st_fail_d = (st_fail_q == COUNT_MAX) ? st_fail_q : st_fail_q + 1'b1;
                if (s_axis_tdata[1]) begin
                  st_yaw_d = (st_yaw_q == COUNT_MAX) ? st_yaw_q : st_yaw_q + 1'b1;
                end
                if (s_axis_tdata[2]) begin
                  st_vel_d = (st_vel_q == COUNT_MAX) ? st_vel_q : st_vel_q + 1'b1;
                end
              end
            end else begin
              // rejected step: counters cleared, window untouched
              st_att_d  = '0;
              st_fail_d = '0;
              st_yaw_d  = '0;
              st_vel_d  = '0;
            end
            // state seen by the result is unchanged by this transaction
            if (out_free) begin
              out_vld_d  = 1'b1;
              out_data_d = snap_data;
              out_user_d = ratio_ok_q;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end

      S_UPD: begin
        ram_we = 1'b1;
        if (win_full) begin
          ram_waddr  = oldest_q;
          oldest_d   = (oldest_q == SLOT_BITS'(WINDOW_STEPS - 1)) ? '0 : oldest_q + 1'b1;
          sum_att_d  = sum_att_q + SUM_BITS'(st_att_q) - SUM_BITS'(old_slot.att);
          sum_fail_d = sum_fail_q + SUM_BITS'(st_fail_q) - SUM_BITS'(old_slot.fail);
          sum_yaw_d  = sum_yaw_q + SUM_BITS'(st_yaw_q) - SUM_BITS'(old_slot.yaw);
          sum_vel_d  = sum_vel_q + SUM_BITS'(st_vel_q) - SUM_BITS'(old_slot.vel);
        end else begin
          ram_waddr  = free_slot;
          fill_d     = fill_q + 1'b1;
          sum_att_d  = sum_att_q + SUM_BITS'(st_att_q);
          sum_fail_d = sum_fail_q + SUM_BITS'(st_fail_q);
          sum_yaw_d  = sum_yaw_q + SUM_BITS'(st_yaw_q);
          sum_vel_d  = sum_vel_q + SUM_BITS'(st_vel_q);
        end
        st_att_d  = '0;
        st_fail_d = '0;
        st_yaw_d  = '0;
        st_vel_d  = '0;
        state_d   = S_PREP;
      end

      S_PREP: begin
        if (sum_att_q == '0) begin
          ratio_d[0] = '0;
          ratio_d[1] = '0;
          ratio_d[2] = '0;
          ratio_ok_d = 1'b0;
          state_d    = S_EMIT;
        end else begin
          sel_d   = R_FAIL;
          cnt_d   = '0;
          rem_d   = REM_BITS'(sum_fail_q);
          quo_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        quo_d = quo_next;
        rem_d = {rem_sub[REM_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_BITS'(RATIO_BITS - 1)) begin
          ratio_d[sel_q] = quo_next;
          cnt_d          = '0;
          quo_d          = '0;
          rem_d          = REM_BITS'(next_num);
          if (sel_q == R_VEL) begin
            ratio_ok_d = 1'b1;
            state_d    = S_EMIT;
          end else begin
            sel_d = (sel_q == R_FAIL) ? R_YAW : R_VEL;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = snap_data;
          out_user_d = ratio_ok_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      min_att_q  <= CFG_BITS'(1);
      st_att_q   <= '0;
      st_fail_q  <= '0;
      st_yaw_q   <= '0;
      st_vel_q   <= '0;
      fill_q     <= '0;
      oldest_q   <= '0;
      sum_att_q  <= '0;
      sum_fail_q <= '0;
      sum_yaw_q  <= '0;
      sum_vel_q  <= '0;
      ratio_q[0] <= '0;
      ratio_q[1] <= '0;
      ratio_q[2] <= '0;
      ratio_ok_q <= 1'b0;
      sel_q      <= R_FAIL;
      cnt_q      <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_user_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      min_att_q  <= min_att_d;
      st_att_q   <= st_att_d;
      st_fail_q  <= st_fail_d;
      st_yaw_q   <= st_yaw_d;
      st_vel_q   <= st_vel_d;
      fill_q     <= fill_d;
      oldest_q   <= oldest_d;
      sum_att_q  <= sum_att_d;
      sum_fail_q <= sum_fail_d;
      sum_yaw_q  <= sum_yaw_d;
      sum_vel_q  <= sum_vel_d;
      ratio_q    <= ratio_d;
      ratio_ok_q <= ratio_ok_d;
      sel_q      <= sel_d;
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      quo_q      <= quo_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[rtl/core/wfr_checker.sv]
// Port-level assertions for the windowed failure ratio statistics core, with its bind.
module wfr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wfr_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  input logic [wfr_pkg::M_TUSER_BITS-1:0] m_axis_tuser
);

  import wfr_pkg::*;

  ratio_t r_fail, r_yaw, r_vel;

  assign r_fail = m_axis_tdata[RATIO_BITS-1:0];
  assign r_yaw  = m_axis_tdata[2*RATIO_BITS-1:RATIO_BITS];
  assign r_vel  = m_axis_tdata[3*RATIO_BITS-1:2*RATIO_BITS];

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // invalid ratios read as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> r_fail == '0 && r_yaw == '0 && r_vel == '0)
    else $error("nonzero ratio while ratios not valid");

  // yaw and velocity failures are subsets of failures, which never exceed attempts
  a_ratio_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> r_fail <= RATIO_ONE && r_yaw <= r_fail && r_vel <= r_fail)
    else $error("ratio ordering broken");

endmodule

bind windowed_failure_ratio_stats_core wfr_checker u_wfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[sim/windowed_failure_ratio_stats_checker.sv]
// Scoreboard for the failure ratio core: predicts each result from accepted transactions.
`timescale 1ns / 100ps

module windowed_failure_ratio_stats_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wfr_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [wfr_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  input  logic [wfr_pkg::S_TUSER_BITS-1:0] s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [wfr_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  input  logic [wfr_pkg::M_TUSER_BITS-1:0] m_axis_tuser,
  output int                               fail_count,
  output int                               pending_results,
  output int                               checked_results
);

  import wfr_pkg::*;

  typedef struct packed {
    logic                 ok;
    logic [WSUM_BITS-1:0] wsum;
    ratio_t               vel;
    ratio_t               yaw;
    ratio_t               fail;
  } ratios_t;

  ratios_t ratios_q[$];

  logic [CFG_BITS-1:0] min_att;
  count_t              cur_att, cur_fail, cur_yaw, cur_vel;
  slot_t               win[WINDOW_STEPS];
  int unsigned         fill, head;
  sum_t                sum_att, sum_fail, sum_yaw, sum_vel;
  ratio_t              q_fail, q_yaw, q_vel;
  logic                q_ok;
  int                  fails, checked;

  function automatic count_t bump(input count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

  // Truncating Q1.16 quotient
  function automatic ratio_t q16(input sum_t num, input sum_t den);
    logic [63:0] wide;
    wide = 64'(num) << FRAC_BITS;
    return ratio_t'(wide / 64'(den));
  endfunction

  task automatic clear_model();
    min_att  = CFG_BITS'(1);
    cur_att  = '0;
    cur_fail = '0;
    cur_yaw  = '0;
    cur_vel  = '0;
    fill     = 0;
    head     = 0;
    sum_att  = '0;
    sum_fail = '0;
    sum_yaw  = '0;
    sum_vel  = '0;
    q_fail   = '0;
    q_yaw    = '0;
    q_vel    = '0;
    q_ok     = 1'b0;
    fails    = 0;
    checked  = 0;
    ratios_q.delete();
  endtask

  // End of step: push the step into the window when it has enough attempts
  task automatic retire_step();
    int unsigned slot;
    if (cur_att >= min_att) begin
      if (fill >= WINDOW_STEPS) begin
        slot     = head;
        sum_att  = sum_att - sum_t'(win[slot].att);
        sum_fail = sum_fail - sum_t'(win[slot].fail);
        sum_yaw  = sum_yaw - sum_t'(win[slot].yaw);
        sum_vel  = sum_vel - sum_t'(win[slot].vel);
        head     = (slot + 1) % WINDOW_STEPS;
      end else begin
        slot = (head + fill) % WINDOW_STEPS;
        fill++;
      end
      win[slot].att  = cur_att;
      win[slot].fail = cur_fail;
      win[slot].yaw  = cur_yaw;
      win[slot].vel  = cur_vel;
      sum_att  = sum_att + sum_t'(cur_att);
      sum_fail = sum_fail + sum_t'(cur_fail);
      sum_yaw  = sum_yaw + sum_t'(cur_yaw);
      sum_vel  = sum_vel + sum_t'(cur_vel);
      if (sum_att != '0) begin
        q_fail = q16(sum_fail, sum_att);
        q_yaw  = q16(sum_yaw, sum_att);
        q_vel  = q16(sum_vel, sum_att);
        q_ok   = 1'b1;
      end else begin
        // no attempts in the window: no division, ratios drop back to invalid
        q_fail = '0;
        q_yaw  = '0;
        q_vel  = '0;
        q_ok   = 1'b0;
      end
    end
    cur_att  = '0;
    cur_fail = '0;
    cur_yaw  = '0;
    cur_vel  = '0;
  endtask

  task automatic predict_item(input logic req, input logic succ, input logic yaw,
                              input logic vel);
    ratios_t r;
    if (req == REQ_ATTEMPT) begin
      cur_att = bump(cur_att);
      if (!succ) begin
        cur_fail = bump(cur_fail);
        if (yaw) cur_yaw = bump(cur_yaw);
        if (vel) cur_vel = bump(cur_vel);
      end
    end else begin
      retire_step();
    end
    r.fail = q_fail;
    r.yaw  = q_yaw;
    r.vel  = q_vel;
    r.ok   = q_ok;
    r.wsum = WSUM_BITS'(sum_att);
    ratios_q = {ratios_q, r};
  endtask

  task automatic compare_result(input logic [M_TDATA_BITS-1:0] d,
                                input logic [M_TUSER_BITS-1:0] u);
    ratios_t got, want;
    logic    bad;
    got.fail = d[0 +: RATIO_BITS];
    got.yaw  = d[RATIO_BITS +: RATIO_BITS];
    got.vel  = d[2*RATIO_BITS +: RATIO_BITS];
    got.wsum = d[3*RATIO_BITS +: WSUM_BITS];
    got.ok   = u[0];
    checked++;
    if (ratios_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("[%0t] ERROR: unexpected result: fail=%0d yaw=%0d vel=%0d ok=%0d wsum=%0d",
                 $time, got.fail, got.yaw, got.vel, got.ok, got.wsum);
    end else begin
      want = ratios_q[0];
      ratios_q.delete(0);
      bad  = (got.fail !== want.fail) || (got.yaw !== want.yaw) || (got.vel !== want.vel) ||
             (got.ok !== want.ok) || (got.wsum !== want.wsum);
      if (bad) begin
        fails++;
        if (fails <= 10) begin
          $display("[%0t] ERROR: result %0d mismatch", $time, checked);
          $display("  expected fail=%0d yaw=%0d vel=%0d ok=%0d wsum=%0d",
                   want.fail, want.yaw, want.vel, want.ok, want.wsum);
          $display("  actual   fail=%0d yaw=%0d vel=%0d ok=%0d wsum=%0d",
                   got.fail, got.yaw, got.vel, got.ok, got.wsum);
        end
      end
    end
  endtask

  // Samples pre-edge values; the counts go out through nonblocking updates
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata, m_axis_tuser);
      if (cfg_we_i) min_att = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser[0], s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2]);
    end
    fail_count      <= fails;
    pending_results <= ratios_q.size();
    checked_results <= checked;
  end

endmodule

[sim/windowed_failure_ratio_stats_core_test.sv]
// Testbench top of the failure ratio core: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 100ps

module windowed_failure_ratio_stats_core_test;
  import wfr_pkg::*;

  localparam int SETTLE_CYCLES = 60;    // longer than a step end takes to produce its result
  localparam int STALL_LIMIT   = 2000;  // cycles without any transaction

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_BITS-1:0]     cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_BITS-1:0] s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;
  logic [M_TUSER_BITS-1:0] m_axis_tuser;
  int                      fail_count;
  int                      pending_results;
  int                      checked_results;

  // Stimulus shaping
  bit sink_free = 1'b0;  // sink never stalls while set
  bit idle_en   = 1'b0;  // source inserts gaps while set
  int sink_hold = 0;
  int n_items   = 0;
  int n_steps   = 0;
  int n_cfg     = 0;

  always #10 clk_i = ~clk_i;

  windowed_failure_ratio_stats_core u_top (.*);

  windowed_failure_ratio_stats_checker u_checker (.*);

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // Result sink: random backpressure unless sink_free is set
  always @(posedge clk_i) begin
    if (sink_free) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) sink_hold <= gap_len();
    end
  end

  // Watchdog: ends the run when the core stops moving transactions
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] ERROR: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // One input transaction; returns at the edge that accepted it
  task automatic send_item(input logic req, input logic succ, input logic yaw,
                           input logic vel);
    int gap;
    gap = (idle_en && ($urandom_range(0, 1) == 1)) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_BITS'({vel, yaw, succ});  // [0] success, [1] yaw, [2] vel
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (req == REQ_STEP_END) n_steps++;
  endtask

  // Stop sending and wait until every result is in and the core is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // min_attempts is only written while the core is idle
  task automatic set_min_attempts(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_cfg++;
  endtask

  // Well-formed steps: a run of attempts with a random failure rate, then the step end
  task automatic random_steps(input int count);
    int sent, len, fail_pct;
    sent = 0;
    while (sent < count) begin
      fail_pct = $urandom_range(0, 100);
      case ($urandom_range(0, 9))
        0:       len = 0;
        9:       len = $urandom_range(7, 30);
        default: len = $urandom_range(1, 6);
      endcase
      repeat (len)
        send_item(REQ_ATTEMPT, $urandom_range(0, 99) >= fail_pct, $urandom_range(0, 1),
                  $urandom_range(0, 1));
      // flags on a step end must be ignored
      send_item(REQ_STEP_END, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      sent += len + 1;
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] min_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset value min_attempts = 1
    idle_en = 1'b1;
    send_item(REQ_ATTEMPT, 1'b1, 1'b0, 1'b0);   // nothing in the window yet
    send_item(REQ_STEP_END, 1'b1, 1'b1, 1'b1);  // first step enters, no failures
    send_item(REQ_STEP_END, 1'b0, 1'b0, 1'b0);  // empty step rejected
    send_item(REQ_ATTEMPT, 1'b0, 1'b1, 1'b0);
    send_item(REQ_ATTEMPT, 1'b0, 1'b0, 1'b1);
    send_item(REQ_ATTEMPT, 1'b0, 1'b1, 1'b1);
    send_item(REQ_ATTEMPT, 1'b0, 1'b0, 1'b0);
    send_item(REQ_ATTEMPT, 1'b1, 1'b1, 1'b1);   // flags ignored on success
    send_item(REQ_STEP_END, 1'b0, 1'b0, 1'b0);
    send_item(REQ_ATTEMPT, 1'b0, 1'b1, 1'b1);
    send_item(REQ_STEP_END, 1'b0, 1'b1, 1'b0);

    // Threshold edge: two attempts rejected, three accepted
    set_min_attempts(CFG_BITS'(3));
    repeat (2) send_item(REQ_ATTEMPT, 1'b0, 1'b1, 1'b0);
    send_item(REQ_STEP_END, 1'b0, 1'b0, 1'b0);
    repeat (3) send_item(REQ_ATTEMPT, 1'b0, 1'b0, 1'b1);
    send_item(REQ_STEP_END, 1'b0, 1'b0, 1'b0);

    // Threshold zero: a full window of empty steps leaves no attempts, ratios invalid
    set_min_attempts('0);
    repeat (WINDOW_STEPS)
      send_item(REQ_STEP_END, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    send_item(REQ_ATTEMPT, 1'b0, 1'b1, 1'b1);

    // Random rounds over several thresholds; one round without idling
    for (int round = 0; round < 5; round++) begin
      case (round)
        0:       min_val = CFG_BITS'(1);
        1:       min_val = '0;
        2:       min_val = CFG_BITS'(2);
        3:       min_val = CFG_BITS'(5);
        default: min_val = CFG_BITS'($urandom_range(0, 4));
      endcase
      set_min_attempts(min_val);
      idle_en   = (round != 2);
      sink_free <= (round == 2);
      random_steps(170);
    end
    sink_free <= 1'b0;

    drain();
    $display("Covered %0d input transactions (%0d step ends), %0d results, %0d threshold writes",
             n_items, n_steps, checked_results, n_cfg);
    $display("with rejected steps, window wrap and an emptied window; %0d mismatches",
             fail_count);
    if (fail_count == 0 && pending_results == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/wfr_pkg.sv
rtl/core/wfr_ram.sv
rtl/core/windowed_failure_ratio_stats_core.sv
rtl/core/wfr_checker.sv
sim/windowed_failure_ratio_stats_checker.sv
sim/windowed_failure_ratio_stats_core_test.sv
